// ===== hdl/weighted_nearest_point_reducer_unit_defines.svh =====
// Assertion macros shared by the weighted nearest point reducer RTL.
// Included by modules that carry concurrent assertions; no other dependency.
`ifndef WEIGHTED_NEAREST_POINT_REDUCER_UNIT_DEFINES_SVH
`define WEIGHTED_NEAREST_POINT_REDUCER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WNPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wnpr assertion failed");
`define WNPR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wnpr assertion failed");
`else
`define WNPR_ASSERT(lbl, clk, rst, prop)
`define WNPR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/wnpr_pkg.sv =====
// Package for the weighted nearest point reducer: word types, register
// indexes, step counts and controller/datapath command and status types.
package wnpr_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 25;
  localparam int CNT_W      = 5;

  typedef enum logic [2:0] {
    REG_MAX_BIDIR  = 3'd0,
    REG_MIN_BIDIR  = 3'd1,
    REG_MAX_WEIGHT = 3'd2,
    REG_MAX_GRAD   = 3'd3,
    REG_BIDIR_MODE = 3'd4
  } wnpr_reg_e;

  typedef enum logic {
    OP_START     = 1'b0,
    OP_CANDIDATE = 1'b1
  } wnpr_op_e;

  typedef struct packed {
    logic               opcode;
    logic [61:0]        dist_sq;
    logic signed [31:0] weight;
    logic [31:0]        point_id;
  } wnpr_in_t;

  typedef struct packed {
    logic signed [31:0] best_dist;
    logic [31:0]        best_id;
    logic               have_best;
    logic               stop_search;
    logic [61:0]        radius_sq;
    logic               radius_shrunk;
    logic               query_dead;
  } wnpr_out_t;

  typedef struct packed {
    logic load;
    logic start_q;
    logic sqrt_step;
    logic calc;
    logic upd;
    logic div_step;
    logic rad;
    logic sq;
    logic out_load;
  } wnpr_cmd_t;

  typedef struct packed {
    logic is_start;
    logic skip;
    logic sqrt_last;
    logic div_last;
    logic go_div;
    logic out_free;
  } wnpr_sts_t;

endpackage

// ===== hdl/weighted_nearest_point_reducer_unit.sv =====
// Top level of the weighted nearest point reducer.
// Depends on wnpr_pkg, wnpr_ctrl and wnpr_datapath.
//
//   channel  | valid     | ready     | word
//   ---------+-----------+-----------+---------------------------
//   input    | in_valid  | in_ready  | in_data   (wnpr_in_t)
//   output   | out_valid | out_ready | out_data  (wnpr_out_t)
//   config   | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// Start word, or candidate of a dead or stopped query: decode, radius square
// and output load. Live candidate: also the 32-step square root, compare and
// update, and the 25-step radix-4 divider when the radius is recomputed.
// Sync reset clears config and query state; config is always ready.
// A new word is taken while the previous result waits in the output register.
module weighted_nearest_point_reducer_unit
  import wnpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  wnpr_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output wnpr_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  wnpr_cmd_t cmd;
  wnpr_sts_t sts;

  assign cfg_ready = 1'b1;

  wnpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wnpr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/wnpr_datapath.sv =====
// Datapath: config registers, query state, iterative square root,
// radix-4 restoring divider, radius square and output register.
// Depends on wnpr_pkg and the shared assertion macro header.
`include "weighted_nearest_point_reducer_unit_defines.svh"
module wnpr_datapath
  import wnpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wnpr_cmd_t   cmd,
  output wnpr_sts_t   sts,
  input  wnpr_in_t    in_data,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output wnpr_out_t   out_data
);

  logic signed [31:0] max_bidir, min_bidir, max_weight;
  logic [23:0]        max_grad;
  logic               bidir_mode;

  logic signed [31:0] best_distance, search_radius, weight_bound;
  logic [31:0]        best_point;
  logic               best_valid, stopped, dead_query, shrunk, halt;

  logic               op;
  logic signed [31:0] w;
  logic [31:0]        pid;
  logic [CNT_W-1:0]   cnt;

  logic [61:0] sq_n;
  logic [62:0] sq_res, sq_bit;
  logic [46:0] prod;
  logic [49:0] dq;
  logic [16:0] rem, den;
  logic        neg;
  logic [63:0] rsq;

  logic [62:0]        sq_trial;
  logic [30:0]        r;
  logic signed [33:0] dist_full;
  logic signed [31:0] cand_dist;
  logic signed [32:0] loc_w;
  logic signed [33:0] start_sum, num_sum;
  logic signed [31:0] start_rad;
  logic [32:0]        num_mag;
  logic [17:0]        d1, d2;
  logic [16:0]        rem1, rem2;
  logic               b1, b2;
  logic signed [31:0] rad;
  logic [31:0]        rad_mag;

  assign r = sq_res[30:0];
  assign sq_trial = sq_res + sq_bit;
  assign dist_full = $signed({3'b000, r}) - $signed({{2{w[31]}}, w});
  assign cand_dist = (dist_full > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                     (dist_full < -34'sh080000000) ? 32'sh80000000 : dist_full[31:0];
  assign loc_w = $signed({w[31], w}) + $signed({2'b00, prod[46:16]});
  assign start_sum = $signed({{2{max_bidir[31]}}, max_bidir}) +
                     $signed({{2{max_weight[31]}}, max_weight});
  assign start_rad = (start_sum > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                     (start_sum < -34'sh080000000) ? 32'sh80000000 : start_sum[31:0];
  assign num_sum = $signed({{2{max_bidir[31]}}, max_bidir}) +
                   $signed({loc_w[32], loc_w});
  assign num_mag = num_sum[33] ? 33'(-num_sum) : num_sum[32:0];

  always_comb begin
    d1 = {rem, dq[49]};
    b1 = (d1 >= {1'b0, den});
    if (b1) begin
      d1 = d1 - {1'b0, den};
    end
    rem1 = d1[16:0];
    d2 = {rem1, dq[48]};
    b2 = (d2 >= {1'b0, den});
    if (b2) begin
      d2 = d2 - {1'b0, den};
    end
    rem2 = d2[16:0];
  end

  always_comb begin
    if (neg) begin
      rad = (dq > 50'h80000000) ? 32'sh80000000 : $signed(32'(~dq[31:0] + 32'd1));
    end else begin
      rad = (dq > 50'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(dq[31:0]);
    end
  end

  assign rad_mag = search_radius[31] ? 32'(-search_radius) : search_radius;

  assign sts.is_start  = (op == OP_START);
  assign sts.skip      = dead_query | stopped;
  assign sts.sqrt_last = (cnt == CNT_W'(SQRT_STEPS - 1));
  assign sts.div_last  = (cnt == CNT_W'(DIV_STEPS - 1));
  assign sts.go_div    = !halt && (max_grad[23:16] == 8'd0) &&
                         (loc_w < $signed({weight_bound[31], weight_bound}));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bidir     <= '0;
      min_bidir     <= '0;
      max_weight    <= '0;
      max_grad      <= '0;
      bidir_mode    <= 1'b0;
      best_distance <= '0;
      search_radius <= '0;
      weight_bound  <= '0;
      best_point    <= '0;
      best_valid    <= 1'b0;
      stopped       <= 1'b0;
      dead_query    <= 1'b0;
      shrunk        <= 1'b0;
      halt          <= 1'b0;
      cnt           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MAX_BIDIR:  max_bidir  <= cfg_data;
          REG_MIN_BIDIR:  min_bidir  <= cfg_data;
          REG_MAX_WEIGHT: max_weight <= cfg_data;
          REG_MAX_GRAD:   max_grad   <= cfg_data[23:0];
          REG_BIDIR_MODE: bidir_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        shrunk <= 1'b0;
        halt   <= 1'b0;
        cnt    <= '0;
      end
      if (cmd.start_q) begin
        best_distance <= max_bidir;
        best_point    <= '0;
        best_valid    <= 1'b0;
        stopped       <= 1'b0;
        weight_bound  <= max_weight;
        search_radius <= start_rad;
        dead_query    <= start_rad[31];
      end
      if (cmd.sqrt_step || cmd.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.calc && (cand_dist < best_distance)) begin
        best_distance <= cand_dist;
        best_point    <= pid;
        best_valid    <= 1'b1;
        if (bidir_mode && (cand_dist < min_bidir)) begin
          stopped <= 1'b1;
          halt    <= 1'b1;
        end
      end
      if (cmd.upd) begin
        weight_bound <= loc_w[31:0];
        cnt          <= '0;
      end
      if (cmd.rad && (rad < search_radius)) begin
        search_radius <= rad;
        shrunk        <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_data.opcode;
      w      <= in_data.weight;
      pid    <= in_data.point_id;
      sq_n   <= in_data.dist_sq;
      sq_res <= '0;
      sq_bit <= 63'(1) << 62;
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, sq_n} >= sq_trial) begin
        sq_n   <= sq_n - sq_trial[61:0];
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.calc) begin
      prod <= r * max_grad[15:0];
    end
    if (cmd.upd) begin
      neg <= num_sum[33];
      dq  <= {1'b0, num_mag, 16'd0};
      rem <= '0;
      den <= 17'h10000 - {1'b0, max_grad[15:0]};
    end
    if (cmd.div_step) begin
      dq  <= {dq[47:0], b1, b2};
      rem <= rem2;
    end
    if (cmd.sq) begin
      rsq <= rad_mag * rad_mag;
    end
    if (cmd.out_load) begin
      out_data.best_dist     <= best_distance;
      out_data.best_id       <= best_point;
      out_data.have_best     <= best_valid;
      out_data.stop_search   <= stopped;
      out_data.radius_sq     <= dead_query ? 62'd0 :
                                (rsq[63:62] != 2'b00) ? {62{1'b1}} : rsq[61:0];
      out_data.radius_shrunk <= shrunk;
      out_data.query_dead    <= dead_query;
    end
  end

  `WNPR_ASSERT(a_stop_has_best, clk, rst, stopped |-> best_valid)
  `WNPR_ASSERT(a_dead_no_best, clk, rst, dead_query |-> !best_valid)
  `WNPR_ASSERT(a_shrunk_live, clk, rst, shrunk |-> !dead_query && !stopped)

endmodule

// ===== hdl/wnpr_ctrl.sv =====
// Controller: sequences one word through decode, root, compare, divide,
// radius square and output load. Depends on wnpr_pkg and the macro header.
`include "weighted_nearest_point_reducer_unit_defines.svh"
module wnpr_ctrl
  import wnpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  wnpr_sts_t sts,
  output wnpr_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SQRT, S_CALC, S_UPD, S_DIV, S_RAD, S_SQ, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_start) begin
          cmd.start_q = 1'b1;
          state_next = S_SQ;
        end else if (sts.skip) begin
          state_next = S_SQ;
        end else begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (sts.go_div) begin
          cmd.upd = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_SQ;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_RAD;
        end
      end
      S_RAD: begin
        cmd.rad = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `WNPR_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)

endmodule
